>>> rtl/core/tick_timer_task_table_macros.svh
// Assertion helpers for the tick timer task table
`ifndef TICK_TIMER_TASK_TABLE_MACROS_SVH
`define TICK_TIMER_TASK_TABLE_MACROS_SVH

// Assert a property on the rising clock, ignored while in reset
`define TTT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assert an implication on the rising clock, ignored while in reset
`define TTT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/ttt_pkg.sv
`timescale 1ns / 1ps
package ttt_pkg;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_CANCEL = 2'd1,
    ACT_TICK   = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    KIND_ADDED = 2'd0,
    KIND_FIRED = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_FULL  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] handle;
    logic [63:0] due;
    logic [31:0] period;
    logic        rpt;
  } slot_t;

  // Request from the sequencer to the slot store
  typedef struct packed {
    logic  wr_en;
    slot_t wr_data;
  } slot_wr_t;

endpackage

>>> rtl/core/tick_timer_task_table.sv
`timescale 1ns / 1ps
// Channel  | handshake                 | fields
// request  | in_valid_i / in_stall_o   | action_i .. current_tick_i
// result   | out_valid_o / out_stall_i | kind_o, out_id_o, out_handle_o, last_o
//
// An add answers in the cycle after it is taken. A cancel walks all n slots, each
// with a registered read and then a shift down, and then closes. A tick walks all
// n slots the same way (read, then compare and compact) and then gives its done
// result; the first tick skips the walk. The single read port of the slot store
// and the shared 64-bit due adder set the pace.
// Reset clears count, id counter, tick and started flag; slots need no clearing.
// A stalled result holds the sequencer; the request side is stalled while busy or while a result waits.
`include "tick_timer_task_table_macros.svh"
module tick_timer_task_table #(
  parameter int unsigned MAX_TASKS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [31:0] handle_i,
  input  logic [31:0] delay_ticks_i,
  input  logic [31:0] period_ticks_i,
  input  logic        repeat_flag_i,
  input  logic [31:0] task_id_i,
  input  logic [62:0] current_tick_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [31:0] out_id_o,
  output logic [31:0] out_handle_o,
  output logic        last_o
);

  localparam int unsigned AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CW = $clog2(MAX_TASKS + 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_READ  = 6'b000010,
    ST_EVAL  = 6'b000100,
    ST_SHIFT = 6'b001000,
    ST_OUT   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   rd_q, rd_d;     // slot being read
  logic [CW-1:0]   wr_q, wr_d;     // compaction write pointer
  logic [CW-1:0]   n_q, n_d;       // slots present at start of walk
  logic [31:0]     next_id_q, next_id_d;
  logic [63:0]     now_q, now_d;
  logic            started_q, started_d;
  logic            is_tick_q, is_tick_d;
  logic            found_q, found_d;
  logic [31:0]     cid_q, cid_d;
  logic [1:0]      kind_q, kind_d;
  logic [31:0]     oid_q, oid_d, ohdl_q, ohdl_d;
  logic            last_q, last_d;
  logic            ovalid_q, ovalid_d;

  ttt_pkg::slot_t    rd_data;
  ttt_pkg::slot_wr_t wr;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  logic [31:0]       dly, per;
  logic [31:0]       addend;
  logic [63:0]       due_sum;
  logic              due_hit;
  logic              fired_out;

  assign rd_addr = rd_q[AW-1:0];
  assign due_hit = rd_data.due <= now_q;
  assign dly     = (delay_ticks_i == 32'd0) ? 32'd1 : delay_ticks_i;
  assign per     = (period_ticks_i == 32'd0) ? 32'd1 : period_ticks_i;
  // One adder serves both the first due tick of an add and a reschedule
  assign addend  = (state_q == ST_IDLE) ? dly : rd_data.period;
  assign due_sum = now_q + {32'd0, addend};

  ttt_slot_store #(.Depth(MAX_TASKS), .AW(AW)) u_store (
    .clk_i     (clk_i),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_addr_i (wr_addr),
    .wr_i      (wr)
  );

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    rd_d      = rd_q;
    wr_d      = wr_q;
    n_d       = n_q;
    next_id_d = next_id_q;
    now_d     = now_q;
    started_d = started_q;
    is_tick_d = is_tick_q;
    found_d   = found_q;
    cid_d     = cid_q;
    kind_d    = kind_q;
    oid_d     = oid_q;
    ohdl_d    = ohdl_q;
    last_d    = last_q;
    ovalid_d  = ovalid_q;
    wr        = '0;
    wr_addr   = wr_q[AW-1:0];
    if (ovalid_q && !out_stall_i) begin
      ovalid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && !ovalid_q) begin
          case (action_i)
            ttt_pkg::ACT_ADD: begin
              ovalid_d = 1'b1;
              last_d   = 1'b1;
              if (count_q >= CW'(MAX_TASKS)) begin
                kind_d = ttt_pkg::KIND_FULL;
                oid_d  = '0;
                ohdl_d = '0;
              end else begin
                wr.wr_en           = 1'b1;
                wr_addr            = count_q[AW-1:0];
                wr.wr_data.id      = next_id_q;
                wr.wr_data.handle  = handle_i;
                wr.wr_data.due     = due_sum;
                wr.wr_data.period  = per;
                wr.wr_data.rpt     = repeat_flag_i;
                count_d   = count_q + CW'(1);
                kind_d    = ttt_pkg::KIND_ADDED;
                oid_d     = next_id_q;
                ohdl_d    = handle_i;
                next_id_d = next_id_q + 32'd1;
              end
            end
            ttt_pkg::ACT_CANCEL: begin
              is_tick_d = 1'b0;
              found_d   = 1'b0;
              cid_d     = task_id_i;
              n_d       = count_q;
              rd_d      = '0;
              wr_d      = '0;
              state_d   = ST_READ;
            end
            ttt_pkg::ACT_TICK: begin
              now_d = {1'b0, current_tick_i};
              if (!started_q) begin
                started_d = 1'b1;
                state_d   = ST_DONE;
              end else begin
                is_tick_d = 1'b1;
                n_d       = count_q;
                rd_d      = '0;
                wr_d      = '0;
                state_d   = ST_READ;
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        // Wait for the registered read of slot rd_q
        if (rd_q >= n_q) begin
          if (is_tick_q) begin
            count_d = wr_q;
            state_d = ST_DONE;
          end else begin
            if (found_q) count_d = count_q - CW'(1);
            state_d = ST_IDLE;
          end
        end else begin
          state_d = is_tick_q ? ST_EVAL : ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        // Cancel: drop the first match, move the rest down one
        if (!found_q && rd_data.id == cid_q) begin
          found_d = 1'b1;
        end else begin
          wr.wr_en   = 1'b1;
          wr.wr_data = rd_data;
          wr_d       = wr_q + CW'(1);
        end
        rd_d    = rd_q + CW'(1);
        state_d = ST_READ;
      end
      ST_EVAL: begin
        if (due_hit) begin
          if (!ovalid_q || !out_stall_i) begin
            ovalid_d = 1'b1;
            kind_d   = ttt_pkg::KIND_FIRED;
            oid_d    = rd_data.id;
            ohdl_d   = rd_data.handle;
            last_d   = 1'b0;
            if (rd_data.rpt) begin
              wr.wr_en       = 1'b1;
              wr.wr_data     = rd_data;
              wr.wr_data.due = due_sum;
              wr_d           = wr_q + CW'(1);
            end
            rd_d    = rd_q + CW'(1);
            state_d = ST_READ;
          end
        end else begin
          wr.wr_en   = 1'b1;
          wr.wr_data = rd_data;
          wr_d       = wr_q + CW'(1);
          rd_d       = rd_q + CW'(1);
          state_d    = ST_READ;
        end
      end
      ST_DONE: begin
        if (!ovalid_q || !out_stall_i) begin
          ovalid_d = 1'b1;
          kind_d   = ttt_pkg::KIND_DONE;
          oid_d    = '0;
          ohdl_d   = '0;
          last_d   = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      rd_q      <= '0;
      wr_q      <= '0;
      n_q       <= '0;
      next_id_q <= '0;
      now_q     <= '0;
      started_q <= 1'b0;
      is_tick_q <= 1'b0;
      found_q   <= 1'b0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      rd_q      <= rd_d;
      wr_q      <= wr_d;
      n_q       <= n_d;
      next_id_q <= next_id_d;
      now_q     <= now_d;
      started_q <= started_d;
      is_tick_q <= is_tick_d;
      found_q   <= found_d;
      ovalid_q  <= ovalid_d;
    end
  end

  // Payload registers hold while stalled
  always_ff @(posedge clk_i) begin
    cid_q  <= cid_d;
    kind_q <= kind_d;
    oid_q  <= oid_d;
    ohdl_q <= ohdl_d;
    last_q <= last_d;
  end

  assign in_stall_o   = (state_q != ST_IDLE) || ovalid_q;
  assign out_valid_o  = ovalid_q;
  assign kind_o       = kind_q;
  assign out_id_o     = oid_q;
  assign out_handle_o = ohdl_q;
  assign last_o       = last_q;
  assign fired_out    = out_valid_o && (kind_o == ttt_pkg::KIND_FIRED);

  `TTT_ASSERT(a_count_range, clk_i, rst_ni, count_q <= CW'(MAX_TASKS), "task count overflow")
  `TTT_ASSERT(a_wr_behind_rd, clk_i, rst_ni, wr_q <= rd_q, "compaction pointer ahead")
  `TTT_ASSERT_IMP(a_fire_not_last, clk_i, rst_ni, fired_out, !last_o, "fired marked last")
endmodule

>>> rtl/core/ttt_slot_store.sv
`timescale 1ns / 1ps
module ttt_slot_store #(
  parameter int unsigned Depth = 32,
  parameter int unsigned AW    = 5
) (
  input  logic                clk_i,
  input  logic [AW-1:0]       rd_addr_i,
  output ttt_pkg::slot_t      rd_data_o,
  input  logic [AW-1:0]       wr_addr_i,
  input  ttt_pkg::slot_wr_t   wr_i
);

  ttt_pkg::slot_t mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_i.wr_data;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned TASK_SLOTS = 32;
  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned RANDOM_REQS = 424;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  action_i = ttt_pkg::ACT_NONE;
  logic [31:0] handle_i = '0;
  logic [31:0] delay_ticks_i = '0;
  logic [31:0] period_ticks_i = '0;
  logic        repeat_flag_i = 1'b0;
  logic [31:0] task_id_i = '0;
  logic [62:0] current_tick_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  kind_o;
  logic [31:0] out_id_o;
  logic [31:0] out_handle_o;
  logic        last_o;

  tick_timer_task_table #(.MAX_TASKS(TASK_SLOTS)) dut (.*);

  always #1 clk_i = ~clk_i;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] handle;
    logic [31:0] delay;
    logic [31:0] period;
    logic        rpt;
    logic [31:0] cid;
    logic [62:0] tick;
  } timer_req_t;

  typedef struct packed {
    ttt_pkg::kind_e kind;
    logic [31:0]    id;
    logic [31:0]    handle;
    logic           last;
  } timer_result_t;

  // One row of the directed table; the typed result, where given, replaces
  // the predicted one for that request
  typedef struct packed {
    timer_req_t    req;
    bit            has_exp;
    timer_result_t want_res;
  } plan_row_t;

  // Predictor copy of the task table
  logic [31:0] tbl_id[TASK_SLOTS];
  logic [31:0] tbl_handle[TASK_SLOTS];
  logic [63:0] tbl_due[TASK_SLOTS];
  logic [31:0] tbl_period[TASK_SLOTS];
  logic        tbl_rpt[TASK_SLOTS];
  int unsigned tbl_count = 0;
  logic [31:0] id_counter = '0;
  logic [63:0] tick_now = '0;
  logic        ticking = 1'b0;

  timer_result_t pending_results[$];
  plan_row_t     plan_rows[$];
  int unsigned   fail_count = 0;
  int unsigned   idle_cycles = 0;
  bit            calm = 1'b0;  // no idling in the closing stretch

  function automatic void enqueue_result(input timer_result_t x);
    pending_results.insert(pending_results.size(), x);
  endfunction

  function automatic void add_row(input timer_req_t r, input bit has_exp,
                                  input timer_result_t want_res);
    plan_row_t row;
    row.req = r;
    row.has_exp = has_exp;
    row.want_res = want_res;
    plan_rows.insert(plan_rows.size(), row);
  endfunction

  // Work out the results of one accepted request and queue them
  task automatic predict_timer(input timer_req_t r);
    int unsigned w;
    bit keep;
    case (ttt_pkg::action_e'(r.action))
      ttt_pkg::ACT_ADD: begin
        if (tbl_count >= TASK_SLOTS) begin
          enqueue_result('{ttt_pkg::KIND_FULL, 32'd0, 32'd0, 1'b1});
        end else begin
          tbl_id[tbl_count] = id_counter;
          tbl_handle[tbl_count] = r.handle;
          tbl_due[tbl_count] = tick_now + 64'(r.delay == 0 ? 32'd1 : r.delay);
          tbl_period[tbl_count] = r.period == 0 ? 32'd1 : r.period;
          tbl_rpt[tbl_count] = r.rpt;
          tbl_count++;
          enqueue_result('{ttt_pkg::KIND_ADDED, id_counter, r.handle, 1'b1});
          id_counter = id_counter + 32'd1;
        end
      end
      ttt_pkg::ACT_CANCEL: begin
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_id[i] == r.cid) begin
            for (int j = i; j + 1 < tbl_count; j++) begin
              tbl_id[j] = tbl_id[j+1];
              tbl_handle[j] = tbl_handle[j+1];
              tbl_due[j] = tbl_due[j+1];
              tbl_period[j] = tbl_period[j+1];
              tbl_rpt[j] = tbl_rpt[j+1];
            end
            tbl_count--;
            break;
          end
        end
      end
      ttt_pkg::ACT_TICK: begin
        tick_now = {1'b0, r.tick};
        if (ticking) begin
          w = 0;
          for (int i = 0; i < tbl_count; i++) begin
            keep = 1'b1;
            if (tbl_due[i] <= tick_now) begin
              enqueue_result('{ttt_pkg::KIND_FIRED, tbl_id[i], tbl_handle[i], 1'b0});
              if (tbl_rpt[i]) tbl_due[i] = tick_now + 64'(tbl_period[i]);
              else keep = 1'b0;
            end
            if (keep) begin
              tbl_id[w] = tbl_id[i];
              tbl_handle[w] = tbl_handle[i];
              tbl_due[w] = tbl_due[i];
              tbl_period[w] = tbl_period[i];
              tbl_rpt[w] = tbl_rpt[i];
              w++;
            end
          end
          tbl_count = w;
        end
        ticking = 1'b1;
        enqueue_result('{ttt_pkg::KIND_DONE, 32'd0, 32'd0, 1'b1});
      end
      default: ;
    endcase
  endtask

  // Drive one request and hold it until it is taken; valid stays high
  // into the next request unless an idle burst drops it
  task automatic send_request(input timer_req_t r, input bit has_exp,
                              input timer_result_t want_res);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= r.action;
    handle_i <= r.handle;
    delay_ticks_i <= r.delay;
    period_ticks_i <= r.period;
    repeat_flag_i <= r.rpt;
    task_id_i <= r.cid;
    current_tick_i <= r.tick;
    do @(posedge clk_i); while (in_stall_o);
    predict_timer(r);
    if (has_exp) pending_results[$] = want_res;
    @(negedge clk_i);
  endtask

  // Result side: random stall bursts, compare at the rising edge
  initial begin
    int unsigned burst;
    burst = 0;
    forever begin
      @(negedge clk_i);
      if (burst > 0) burst--;
      else if (!calm && $urandom_range(0, 7) == 0) burst = $urandom_range(1, 6);
      out_stall_i <= (burst > 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result kind %0d id %0h", $time, kind_o, out_id_o);
        fail_count++;
      end else begin
        timer_result_t want;
        want = pending_results.pop_front();
        if (kind_o !== want.kind || out_id_o !== want.id ||
            out_handle_o !== want.handle || last_o !== want.last) begin
          $display("%0t: expected kind %0d id %0h handle %0h last %0b, got %0d %0h %0h %0b",
                   $time, want.kind, want.id, want.handle, want.last,
                   kind_o, out_id_o, out_handle_o, last_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: count cycles with no handshake at all
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tick_timer_task_table verification failed");
      $finish;
    end
  end

  function automatic timer_req_t mk(input logic [1:0] a, input logic [31:0] h,
                                    input logic [31:0] d, input logic [31:0] p,
                                    input logic rp, input logic [31:0] c,
                                    input logic [62:0] t);
    mk = '{a, h, d, p, rp, c, t};
  endfunction

  initial begin
    timer_req_t    r;
    int unsigned   pick;
    logic [62:0]   tk;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: first tick records only, adds with zero and full-scale fields,
    // repeating and one-shot firing, cancel, unknown cancel, unused action,
    // backwards tick, then a full table.
    add_row(mk(ttt_pkg::ACT_TICK, '0, '0, '0, 1'b0, '0, 63'd5), 1'b1,
            '{ttt_pkg::KIND_DONE, 32'd0, 32'd0, 1'b1});
    add_row(mk(ttt_pkg::ACT_ADD, 32'hFFFF_FFFF, '0, '0, 1'b1, '0, '0), 1'b1,
            '{ttt_pkg::KIND_ADDED, 32'd0, 32'hFFFF_FFFF, 1'b1});
    add_row(mk(ttt_pkg::ACT_ADD, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0, '0),
            1'b0, '0);
    add_row(mk(ttt_pkg::ACT_ADD, 32'hA5A5_5A5A, 32'd2, 32'd3, 1'b0, '0, '0), 1'b0, '0);
    add_row(mk(ttt_pkg::ACT_NONE, 32'hFFFF_FFFF, 32'd1, 32'd1, 1'b1, 32'hFFFF_FFFF, '1),
            1'b0, '0);
    add_row(mk(ttt_pkg::ACT_TICK, '0, '0, '0, 1'b0, '0, 63'd6), 1'b0, '0);
    add_row(mk(ttt_pkg::ACT_TICK, '0, '0, '0, 1'b0, '0, 63'd7), 1'b0, '0);
    add_row(mk(ttt_pkg::ACT_CANCEL, '0, '0, '0, 1'b0, 32'hFFFF_FFFF, '0), 1'b0, '0);
    add_row(mk(ttt_pkg::ACT_CANCEL, '0, '0, '0, 1'b0, 32'd1, '0), 1'b0, '0);
    add_row(mk(ttt_pkg::ACT_TICK, '0, '0, '0, 1'b0, '0, 63'd2), 1'b0, '0);
    add_row(mk(ttt_pkg::ACT_TICK, '0, '0, '0, 1'b0, '0, '1), 1'b0, '0);
    // One task is left, so the last three adds find the table full
    for (int i = 0; i < TASK_SLOTS + 2; i++) begin
      if (i >= TASK_SLOTS - 1)
        add_row(mk(ttt_pkg::ACT_ADD, $urandom, 32'($urandom_range(0, 4)),
                   32'($urandom_range(0, 3)), 1'($urandom), '0, '0), 1'b1,
                '{ttt_pkg::KIND_FULL, 32'd0, 32'd0, 1'b1});
      else
        add_row(mk(ttt_pkg::ACT_ADD, $urandom, 32'($urandom_range(0, 4)),
                   32'($urandom_range(0, 3)), 1'($urandom), '0, '0), 1'b0, '0);
    end
    add_row(mk(ttt_pkg::ACT_TICK, '0, '0, '0, 1'b0, '0, '0), 1'b0, '0);
    foreach (plan_rows[i]) send_request(plan_rows[i].req, plan_rows[i].has_exp,
                                        plan_rows[i].want_res);

    // Pause until every queued result has come back
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);

    // Random part: mostly adds and ticks on a slowly advancing clock
    tk = 63'd10;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n == RANDOM_REQS - 60) calm = 1'b1;
      pick = $urandom_range(0, 99);
      r = mk(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, 1'($urandom),
             $urandom, 63'({$urandom, $urandom}));
      if (pick < 40) begin
        r.action = ttt_pkg::ACT_ADD;
        if ($urandom_range(0, 3) != 0) begin
          r.delay = $urandom_range(0, 8);
          r.period = $urandom_range(0, 6);
        end
      end else if (pick < 75) begin
        r.action = ttt_pkg::ACT_TICK;
        tk = tk + 63'($urandom_range(0, 4));
        if ($urandom_range(0, 30) != 0) r.tick = tk;
      end else if (pick < 95) begin
        r.action = ttt_pkg::ACT_CANCEL;
        if ($urandom_range(0, 4) != 0) r.cid = id_counter - 32'($urandom_range(1, 40));
      end
      send_request(r, 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (fail_count == 0) $display("tick_timer_task_table verification clean");
    else $display("tick_timer_task_table verification failed");
    $finish;
  end

endmodule
